// File: sv/igfr_pkg.sv
// Shared constants, command codes and word layouts of the idle gap frame receiver.
`default_nettype none

package igfr_pkg;

	// Default geometry of the receive buffer and the frame ring.
	localparam int SLOT_BYTES_DEF = 512;
	localparam int SLOT_COUNT_DEF = 8;

	// Reset value of the idle gap register.
	localparam logic [15:0] IDLE_GAP_RESET = 16'd100;

	// Command codes carried in the input tuser.
	localparam int CMD_W = 3;
	localparam logic [CMD_W-1:0] CMD_BYTE     = 3'd0;
	localparam logic [CMD_W-1:0] CMD_TICK     = 3'd1;
	localparam logic [CMD_W-1:0] CMD_RD_SLOT  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_RD_RX    = 3'd3;
	localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd4;

	localparam int IN_W  = 24;
	localparam int OUT_W = 32;

	// Input tdata layout, first field in the highest bits.
	typedef struct packed {
		logic [2:0] pad;
		logic [8:0] byte_offset;
		logic [2:0] slot_index;
		logic       connected;
		logic [7:0] rx_byte;
	} in_word_t;

	// Output tdata layout, first field in the highest bits.
	typedef struct packed {
		logic       gap_timer_on;
		logic [8:0] rx_count;
		logic       overflow;
		logic [7:0] read_data;
		logic [8:0] frame_length;
		logic [2:0] frame_slot;
		logic       frame_done;
	} out_word_t;

endpackage

`default_nettype wire

// File: sv/idle_gap_frame_receiver.sv
// Top level of the idle gap frame receiver: receive buffer, gap timer and frame ring.
`default_nettype none

// Channel   Direction  Signals                        Contents
// s_*       in         s_tvalid s_tready s_tdata/tuser one command word
// m_*       out        m_tvalid m_tready m_tdata       one result word per command
// cfg_*     in         cfg_we cfg_wdata                idle gap register, in ticks
//
// A byte, tick without commit, clear or unused command goes from accept straight to
// OUT; a read of either store first passes RD, set by the registered memory read.
// A tick that commits a frame passes HDR_HI, HDR_LO and COPY: two header writes and
// then one data byte per cycle through the single ring write port.
// The input accepts only between commands; a new command is taken while the last
// result still waits, and its result then waits in the OUT state for m_tready.
// Reset clears the counters and control state; both stores hold garbage until written.

module idle_gap_frame_receiver #(
	parameter int SLOT_BYTES = igfr_pkg::SLOT_BYTES_DEF,
	parameter int SLOT_COUNT = igfr_pkg::SLOT_COUNT_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	// rx_byte[7:0], connected[8], slot_index[11:9], byte_offset[20:12], zero pad
	input  wire logic [igfr_pkg::IN_W-1:0]   s_tdata,
	// cmd[2:0]
	input  wire logic [igfr_pkg::CMD_W-1:0]  s_tuser,
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	// frame_done[0], frame_slot[3:1], frame_length[12:4], read_data[20:13],
	// overflow[21], rx_count[30:22], gap_timer_on[31]
	output logic [igfr_pkg::OUT_W-1:0]       m_tdata,
	input  wire logic                        cfg_we,
	input  wire logic [15:0]                 cfg_wdata
);

	localparam int CW       = $clog2(SLOT_BYTES);
	localparam int SW       = $clog2(SLOT_COUNT);
	localparam int RING_D   = SLOT_COUNT * SLOT_BYTES;
	localparam int RAW      = $clog2(RING_D);
	localparam int CAP      = SLOT_BYTES - 2;
	localparam logic [RAW-1:0] SB_R  = RAW'(SLOT_BYTES);
	localparam logic [CW-1:0]  CAP_C = CW'(CAP);
	localparam logic [SW-1:0]  LAST_SLOT = SW'(SLOT_COUNT - 1);

	// Sequencer codes.
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_RD     = 3'd1;
	localparam logic [2:0] ST_HDR_HI = 3'd2;
	localparam logic [2:0] ST_HDR_LO = 3'd3;
	localparam logic [2:0] ST_COPY   = 3'd4;
	localparam logic [2:0] ST_OUT    = 3'd5;

	// The two stores: the receive buffer and the ring of frame slots.
	logic [7:0] rx_mem   [SLOT_BYTES];
	logic [7:0] ring_mem [RING_D];

	logic [2:0]     state_q;
	logic [CW-1:0]  count_q;
	logic [15:0]    gap_cnt_q;
	logic           gap_run_q;
	logic [SW-1:0]  wslot_q;
	logic [15:0]    gap_cfg_q;
	logic           m_tvalid_q;
	logic [CW-1:0]  rd_idx_q;
	logic           copy_v_s1;
	logic [CW-1:0]  wr_idx_s1;
	logic [CW-1:0]  len_q;
	logic [RAW-1:0] base_q;
	logic           rd_ok_q;
	logic           rd_ring_q;
	igfr_pkg::out_word_t res_q;
	igfr_pkg::out_word_t res_d;
	igfr_pkg::out_word_t m_tdata_q;
	igfr_pkg::out_word_t out_w;
	logic [7:0]     rx_rdata_q;
	logic [7:0]     ring_rdata_q;

	igfr_pkg::in_word_t in_w;
	logic           accept;
	logic           out_free;
	logic           byte_kept_cls;
	logic           has_room;
	logic           keep_byte;
	logic           ovf;
	logic           off_ok;
	logic           slot_ok;
	logic [15:0]    gap_eff;
	logic [15:0]    gap_next;
	logic           commit;
	logic [15:0]    count_ext;
	logic [15:0]    len_ext;
	logic [7:0]     wslot_ext;

	logic           rx_we;
	logic           rx_re;
	logic [CW-1:0]  rx_raddr;
	logic           ring_we;
	logic [RAW-1:0] ring_waddr;
	logic [7:0]     ring_wdata;
	logic           ring_re;
	logic [RAW-1:0] ring_raddr;

	assign in_w     = igfr_pkg::in_word_t'(s_tdata);
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && (state_q == ST_IDLE);
	assign out_free = !m_tvalid_q || m_tready;

	// Received byte handling: zero bytes are ignored while the link is down.
	assign byte_kept_cls = in_w.connected || (in_w.rx_byte != 8'd0);
	assign has_room      = (count_q < CAP_C);
	assign keep_byte     = (s_tuser == igfr_pkg::CMD_BYTE) && byte_kept_cls && has_room;
	assign ovf           = (s_tuser == igfr_pkg::CMD_BYTE) && byte_kept_cls && !has_room;

	assign off_ok  = (32'(in_w.byte_offset) < SLOT_BYTES);
	assign slot_ok = (32'(in_w.slot_index) < SLOT_COUNT);

	// Gap timer: a register value of zero behaves as one tick; the counter saturates.
	assign gap_eff  = (gap_cfg_q == 16'd0) ? 16'd1 : gap_cfg_q;
	assign gap_next = (gap_cnt_q != 16'hFFFF) ? gap_cnt_q + 16'd1 : gap_cnt_q;
	assign commit   = gap_run_q && (gap_next >= gap_eff);

	assign count_ext = 16'(count_q);
	assign len_ext   = 16'(len_q);
	assign wslot_ext = 8'(wslot_q);

	// Receive buffer ports: the write comes from an accepted byte, the read from
	// a receive read command or from the frame copy.
	assign rx_we    = accept && keep_byte;
	assign rx_re    = (accept && (s_tuser == igfr_pkg::CMD_RD_RX) && off_ok)
	               || ((state_q == ST_COPY) && (rd_idx_q != len_q));
	assign rx_raddr = (state_q == ST_COPY) ? rd_idx_q : CW'(in_w.byte_offset);

	always_ff @(posedge clk) begin
		if (rx_we)
			rx_mem[count_q] <= in_w.rx_byte;
		if (rx_re)
			rx_rdata_q <= rx_mem[rx_raddr];
	end

	// Ring ports: the header and the copied data go out one word per cycle.
	assign ring_re    = accept && (s_tuser == igfr_pkg::CMD_RD_SLOT) && slot_ok && off_ok;
	assign ring_raddr = RAW'(in_w.slot_index) * SB_R + RAW'(in_w.byte_offset);

	always_comb begin
		ring_we    = 1'b0;
		ring_waddr = base_q;
		ring_wdata = len_ext[15:8];
		case (state_q)
			ST_HDR_HI: begin
				ring_we = 1'b1;
			end
			ST_HDR_LO: begin
				ring_we    = 1'b1;
				ring_waddr = base_q + RAW'(1);
				ring_wdata = len_ext[7:0];
			end
			ST_COPY: begin
				ring_we    = copy_v_s1;
				ring_waddr = base_q + RAW'(2) + RAW'(wr_idx_s1);
				ring_wdata = rx_rdata_q;
			end
			default: begin
				ring_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ring_we)
			ring_mem[ring_waddr] <= ring_wdata;
		if (ring_re)
			ring_rdata_q <= ring_mem[ring_raddr];
	end

	// Control state: sequencer, buffer fill, gap timer, write slot, register, output valid and copy pointer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			gap_cnt_q  <= '0;
			gap_run_q  <= 1'b0;
			wslot_q    <= '0;
			gap_cfg_q  <= igfr_pkg::IDLE_GAP_RESET;
			m_tvalid_q <= 1'b0;
			rd_idx_q   <= '0;
			copy_v_s1  <= 1'b0;
		end else begin
			if (cfg_we)
				gap_cfg_q <= cfg_wdata;

			if ((state_q == ST_OUT) && out_free)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						unique case (s_tuser) inside
							igfr_pkg::CMD_BYTE: begin
								state_q <= ST_OUT;
								if (keep_byte)
									count_q <= count_q + CW'(1);
								if (in_w.connected) begin
									gap_run_q <= 1'b1;
									gap_cnt_q <= '0;
								end
							end
							igfr_pkg::CMD_TICK: begin
								if (commit) begin
									// The frame length and slot base are latched, so the
									// buffer can be marked empty right away.
									count_q   <= '0;
									gap_run_q <= 1'b0;
									gap_cnt_q <= '0;
									wslot_q   <= (wslot_q == LAST_SLOT) ? '0 : wslot_q + SW'(1);
									state_q   <= ST_HDR_HI;
								end else begin
									if (gap_run_q)
										gap_cnt_q <= gap_next;
									state_q <= ST_OUT;
								end
							end
							igfr_pkg::CMD_RD_SLOT, igfr_pkg::CMD_RD_RX: begin
								state_q <= ST_RD;
							end
							igfr_pkg::CMD_CLEAR: begin
								count_q   <= '0;
								gap_run_q <= 1'b0;
								gap_cnt_q <= '0;
								state_q   <= ST_OUT;
							end
							default: begin
								state_q <= ST_OUT;
							end
						endcase
					end
				end
				ST_RD: begin
					state_q <= ST_OUT;
				end
				ST_HDR_HI: begin
					state_q <= ST_HDR_LO;
				end
				ST_HDR_LO: begin
					rd_idx_q  <= '0;
					copy_v_s1 <= 1'b0;
					state_q   <= ST_COPY;
				end
				ST_COPY: begin
					copy_v_s1 <= (rd_idx_q != len_q);
					if (rd_idx_q != len_q)
						rd_idx_q <= rd_idx_q + CW'(1);
					else if (!copy_v_s1)
						state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result fields known at accept time: overflow and the commit report.
	always_comb begin
		res_d          = '0;
		res_d.overflow = ovf;
		if ((s_tuser == igfr_pkg::CMD_TICK) && commit) begin
			res_d.frame_done   = 1'b1;
			res_d.frame_slot   = wslot_ext[2:0];
			res_d.frame_length = count_ext[8:0];
		end
	end

	// Status fields reflect the state after the command, which is final by OUT.
	always_comb begin
		out_w              = res_q;
		out_w.rx_count     = count_ext[8:0];
		out_w.gap_timer_on = gap_run_q;
	end

	// Payload registers: result under construction, copy pointers, output word.
	always_ff @(posedge clk) begin
		if (accept) begin
			res_q     <= res_d;
			rd_ring_q <= (s_tuser == igfr_pkg::CMD_RD_SLOT);
			rd_ok_q   <= (s_tuser == igfr_pkg::CMD_RD_SLOT) ? (slot_ok && off_ok) : off_ok;
			if ((s_tuser == igfr_pkg::CMD_TICK) && commit) begin
				len_q  <= count_q;
				base_q <= RAW'(wslot_q) * SB_R;
			end
		end
		if (state_q == ST_RD)
			res_q.read_data <= !rd_ok_q ? 8'd0 : (rd_ring_q ? ring_rdata_q : rx_rdata_q);
		if (state_q == ST_COPY)
			wr_idx_s1 <= rd_idx_q;
		if ((state_q == ST_OUT) && out_free)
			m_tdata_q <= out_w;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

`default_nettype wire
